// ----- rtl/qrs_pkg.sv -----
package qrs_pkg;

  localparam int SqrtSteps = 25;
  localparam int DivSteps  = 33;

  typedef enum logic [1:0] {
    KIND_TWO  = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_c;
  } operands_t;

  typedef struct packed {
    logic signed [39:0] root_plus;
    logic signed [39:0] root_minus;
    kind_t              root_kind;
  } result_t;

  // Side data that rides along the square root chain.
  typedef struct packed {
    kind_t              kind;
    logic signed [33:0] base;
    logic signed [15:0] dvs;
  } sq_side_t;

  typedef struct packed {
    logic [49:0] rad;
    logic [25:0] rem;
    logic [24:0] root;
  } sq_data_t;

  // Side data that rides along the divider chain.
  typedef struct packed {
    kind_t       kind;
    logic        neg_p;
    logic        neg_m;
    logic [15:0] dvs;
  } dv_side_t;

  typedef struct packed {
    logic [32:0] num_p;
    logic [32:0] num_m;
    logic [15:0] rem_p;
    logic [15:0] rem_m;
  } dv_data_t;

endpackage

// ----- rtl/qrs_sqrt_cell.sv -----
module qrs_sqrt_cell import qrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     vld_in,
  input  sq_side_t side_in,
  input  sq_data_t data_in,
  output logic     vld_out,
  output sq_side_t side_out,
  output sq_data_t data_out
);

  logic [27:0] cur;
  logic [27:0] trial;
  logic [27:0] diff;
  logic        fit;
  sq_data_t    data_next;

  // One result bit per cell: bring down two radicand bits, try 4*root+1.
  always_comb begin
    cur   = {data_in.rem, data_in.rad[49:48]};
    trial = {1'b0, data_in.root, 2'b01};
    diff  = cur - trial;
    fit   = (cur >= trial);
    data_next.rad  = {data_in.rad[47:0], 2'b00};
    data_next.rem  = fit ? diff[25:0] : cur[25:0];
    data_next.root = {data_in.root[23:0], fit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    side_out <= side_in;
    data_out <= data_next;
  end

endmodule

// ----- rtl/qrs_div_cell.sv -----
module qrs_div_cell import qrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     vld_in,
  input  dv_side_t side_in,
  input  dv_data_t data_in,
  output logic     vld_out,
  output dv_side_t side_out,
  output dv_data_t data_out
);

  logic [16:0] cur_p;
  logic [16:0] cur_m;
  logic [16:0] dvs_ext;
  logic [16:0] diff_p;
  logic [16:0] diff_m;
  logic        fit_p;
  logic        fit_m;
  dv_data_t    data_next;

  // Restoring division, one quotient bit per cell for both roots. The
  // quotient bits shift into the numerator register as it empties.
  always_comb begin
    dvs_ext = {1'b0, side_in.dvs};
    cur_p   = {data_in.rem_p, data_in.num_p[32]};
    cur_m   = {data_in.rem_m, data_in.num_m[32]};
    diff_p  = cur_p - dvs_ext;
    diff_m  = cur_m - dvs_ext;
    fit_p   = (cur_p >= dvs_ext);
    fit_m   = (cur_m >= dvs_ext);
    data_next.num_p = {data_in.num_p[31:0], fit_p};
    data_next.num_m = {data_in.num_m[31:0], fit_m};
    data_next.rem_p = fit_p ? diff_p[15:0] : cur_p[15:0];
    data_next.rem_m = fit_m ? diff_m[15:0] : cur_m[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    side_out <= side_in;
    data_out <= data_next;
  end

endmodule

// ----- rtl/quadratic_root_solver.sv -----
// Real roots of a*x^2 + b*x + c = 0 for signed Q8.8 coefficients.
// A coefficient set is taken at each rising edge where start is high and
// busy is low. busy is always low: a new beat may enter on every cycle.
// Each beat yields exactly one result, shown on result for one cycle with
// done high. Results leave in the order the beats entered.
// Inside, the discriminant is formed by two registered multipliers, then
// a row of 25 square root cells produces one root bit each, then a row of
// 33 divider cells produces one quotient bit each for both roots at once.
// Throughput is one beat per cycle.
// root_kind tells two distinct roots, one root (double or linear) or no
// real root; in the last case both roots read zero.
// Reset clears every valid flag in the pipeline, so no done pulse follows
// reset until new beats arrive. The receiver cannot stall: a result that
// is not taken in its cycle is gone.
module quadratic_root_solver import qrs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  operands_t operands,
  output logic      busy,
  output logic      done,
  output result_t   result
);

  logic               v0;
  logic signed [15:0] a0;
  logic signed [15:0] b0;
  logic signed [15:0] c0;
  logic signed [31:0] bb0;
  logic signed [31:0] ac0;
  logic signed [15:0] in_a;
  logic signed [15:0] in_b;
  logic signed [15:0] in_c;

  logic signed [34:0] disc;
  sq_side_t           side1_next;
  sq_data_t           data1_next;

  logic     sq_vld  [0:SqrtSteps];
  sq_side_t sq_side [0:SqrtSteps];
  sq_data_t sq_data [0:SqrtSteps];

  logic     dv_vld  [0:DivSteps];
  dv_side_t dv_side [0:DivSteps];
  dv_data_t dv_data [0:DivSteps];

  sq_side_t           pre_side;
  sq_data_t           pre_data;
  logic [31:0]        s128;
  logic signed [34:0] num_p;
  logic signed [34:0] num_m;
  logic signed [34:0] mag_p;
  logic signed [34:0] mag_m;
  logic [15:0]        dvs_mag;
  dv_side_t           dside_next;
  dv_data_t           ddata_next;

  dv_side_t           fin_side;
  dv_data_t           fin_data;
  logic signed [39:0] qp;
  logic signed [39:0] qm;
  result_t            result_next;

  assign busy = 1'b0;
  assign in_a = operands.coef_a;
  assign in_b = operands.coef_b;
  assign in_c = operands.coef_c;

  // Products stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    a0  <= in_a;
    b0  <= in_b;
    c0  <= in_c;
    bb0 <= 32'(in_b) * 32'(in_b);
    ac0 <= 32'(in_a) * 32'(in_c);
  end

  // Discriminant and case sorting. The numerator before the square root term
  // is -b/2a scaled, or -c/b scaled for the linear equation.
  always_comb begin
    disc = 35'(bb0) - (35'(ac0) <<< 2);
    side1_next.base = (a0 == 16'sd0) ? -(34'(c0) <<< 16) : -(34'(b0) <<< 15);
    side1_next.dvs  = (a0 == 16'sd0) ? b0 : a0;
    if (a0 == 16'sd0) begin
      side1_next.kind = (b0 != 16'sd0) ? KIND_ONE : KIND_NONE;
    end else if (disc < 35'sd0) begin
      side1_next.kind = KIND_NONE;
    end else if (disc == 35'sd0) begin
      side1_next.kind = KIND_ONE;
    end else begin
      side1_next.kind = KIND_TWO;
    end
    data1_next.rad  = (disc < 35'sd0) ? 50'd0 : {disc[33:0], 16'd0};
    data1_next.rem  = '0;
    data1_next.root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else begin
      sq_vld[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    sq_side[0] <= side1_next;
    sq_data[0] <= data1_next;
  end

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .vld_in   (sq_vld[i]),
      .side_in  (sq_side[i]),
      .data_in  (sq_data[i]),
      .vld_out  (sq_vld[i+1]),
      .side_out (sq_side[i+1]),
      .data_out (sq_data[i+1])
    );
  end

  // Numerators and signs for the divider row.
  always_comb begin
    pre_side = sq_side[SqrtSteps];
    pre_data = sq_data[SqrtSteps];
    s128  = (pre_side.kind == KIND_TWO) ? {pre_data.root, 7'd0} : 32'd0;
    num_p = 35'(pre_side.base) + $signed({3'b000, s128});
    num_m = 35'(pre_side.base) - $signed({3'b000, s128});
    mag_p = num_p[34] ? -num_p : num_p;
    mag_m = num_m[34] ? -num_m : num_m;
    dvs_mag = pre_side.dvs[15] ? 16'(-pre_side.dvs) : 16'(pre_side.dvs);
    dside_next.kind  = pre_side.kind;
    dside_next.neg_p = num_p[34] ^ pre_side.dvs[15];
    dside_next.neg_m = num_m[34] ^ pre_side.dvs[15];
    dside_next.dvs   = dvs_mag;
    ddata_next.num_p = mag_p[32:0];
    ddata_next.num_m = mag_m[32:0];
    ddata_next.rem_p = '0;
    ddata_next.rem_m = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= sq_vld[SqrtSteps];
    end
  end

  always_ff @(posedge clk) begin
    dv_side[0] <= dside_next;
    dv_data[0] <= ddata_next;
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .vld_in   (dv_vld[j]),
      .side_in  (dv_side[j]),
      .data_in  (dv_data[j]),
      .vld_out  (dv_vld[j+1]),
      .side_out (dv_side[j+1]),
      .data_out (dv_data[j+1])
    );
  end

  // Apply the quotient signs; the magnitudes never reach the 40-bit limits.
  always_comb begin
    fin_side = dv_side[DivSteps];
    fin_data = dv_data[DivSteps];
    qp = $signed({7'd0, fin_data.num_p});
    qm = $signed({7'd0, fin_data.num_m});
    if (fin_side.kind == KIND_NONE) begin
      result_next.root_plus  = '0;
      result_next.root_minus = '0;
    end else begin
      result_next.root_plus  = fin_side.neg_p ? -qp : qp;
      result_next.root_minus = fin_side.neg_m ? -qm : qm;
    end
    result_next.root_kind = fin_side.kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// ----- test/quadratic_root_solver_tb.sv -----
module quadratic_root_solver_tb;
  import qrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 61;
  localparam int WatchdogLimit = 4000;

  logic      clk;
  logic      rst;
  logic      start;
  operands_t operands;
  logic      busy;
  logic      done;
  result_t   result;

  result_t expected_roots[$];
  int      fail_count;
  int      idle_cycles;
  int      send_idle_pct;
  int      beats_sent;
  int      results_seen;
  int      kind_seen[3];

  quadratic_root_solver DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .operands(operands),
    .busy(busy),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bit_val;
    root = 0;
    bit_val = 64'd1 << 62;
    while (bit_val > n) bit_val >>= 2;
    while (bit_val != 0) begin
      if (n >= root + bit_val) begin
        n -= root + bit_val;
        root = (root >> 1) + bit_val;
      end else begin
        root >>= 1;
      end
      bit_val >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [39:0] clamp_root(longint v);
    if (v > 64'sd549755813887) v = 64'sd549755813887;
    if (v < -64'sd549755813888) v = -64'sd549755813888;
    return v[39:0];
  endfunction

  function automatic result_t solve_roots(operands_t op);
    result_t r;
    longint a, b, c, disc, s;
    a = op.coef_a;
    b = op.coef_b;
    c = op.coef_c;
    r.root_plus = '0;
    r.root_minus = '0;
    r.root_kind = KIND_NONE;
    if (a == 0) begin
      if (b != 0) begin
        r.root_plus = clamp_root((-c * 65536) / b);
        r.root_minus = r.root_plus;
        r.root_kind = KIND_ONE;
      end
    end else begin
      disc = b * b - 4 * a * c;
      if (disc == 0) begin
        r.root_plus = clamp_root((-b * 32768) / a);
        r.root_minus = r.root_plus;
        r.root_kind = KIND_ONE;
      end else if (disc > 0) begin
        s = longint'(int_sqrt(longint'(disc) * 65536));
        r.root_plus = clamp_root(((-b * 256 + s) * 128) / a);
        r.root_minus = clamp_root(((-b * 256 - s) * 128) / a);
        r.root_kind = KIND_TWO;
      end
    end
    return r;
  endfunction

  // Drives one beat and holds it until the edge that takes it.
  task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operands <= '{coef_a: a, coef_b: b, coef_c: c};
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_roots.push_back(solve_roots('{coef_a: a, coef_b: b, coef_c: c}));
    beats_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      result_t exp_r;
      if (expected_roots.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, result);
        fail_count++;
      end else begin
        exp_r = expected_roots.pop_front();
        results_seen++;
        if (result.root_kind <= KIND_NONE) kind_seen[result.root_kind]++;
        if (result.root_plus !== exp_r.root_plus)
          $display("%0t: root_plus expected %0d actual %0d", $time,
                   exp_r.root_plus, result.root_plus);
        if (result.root_minus !== exp_r.root_minus)
          $display("%0t: root_minus expected %0d actual %0d", $time,
                   exp_r.root_minus, result.root_minus);
        if (result.root_kind !== exp_r.root_kind)
          $display("%0t: root_kind expected %0d actual %0d", $time,
                   exp_r.root_kind, result.root_kind);
        if (result !== exp_r) fail_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
        $display("FAIL quadratic_root_solver");
        $finish;
      end
    end
  end

  task automatic test_extremes();
    logic [15:0] ends[4];
    ends = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    foreach (ends[i])
      foreach (ends[j])
        send_coefs(ends[i], ends[j], ends[(i + j) % 4]);
  endtask

  task automatic test_special_cases();
    send_coefs(16'h0100, 16'h0000, 16'h0100);  // negative discriminant
    send_coefs(16'h0100, 16'hfe00, 16'h0100);  // double root at one
    send_coefs(16'h0400, 16'h0400, 16'h0100);  // double root at -1/2
    send_coefs(16'h0000, 16'h0300, 16'hff00);  // linear
    send_coefs(16'h0000, 16'h0000, 16'h1234);  // no equation
    send_coefs(16'h0000, 16'h0000, 16'h0000);
    send_coefs(16'h0100, 16'h0000, 16'hfc00);  // roots at +-2
    send_coefs(16'hff00, 16'h0100, 16'h0600);
  endtask

  // Double roots need b*b == 4ac, so some beats are built that way on purpose.
  task automatic test_random(int count);
    int r, k;
    logic [15:0] a, b, c;
    repeat (count) begin
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
      r = $urandom_range(9);
      if (r == 0) a = '0;
      if (r == 1) begin
        a = '0;
        b = '0;
      end
      if (r == 2) begin
        k = $urandom_range(1, 90);
        a = 16'($urandom_range(1, 32767 / (k * k)));
        if ($urandom_range(1)) a = -a;
        b = 16'(2 * a * k);
        if ($urandom_range(1)) b = -b;
        c = 16'(a * k * k);
      end
      if (r == 3) begin
        a = 16'($urandom_range(1, 255));
        b = 16'($urandom_range(0, 1023));
        c = 16'($urandom_range(0, 1023));
        if ($urandom_range(1)) c = -c;
      end
      send_coefs(a, b, c);
    end
  endtask

  initial begin
    fail_count = 0;
    beats_sent = 0;
    results_seen = 0;
    kind_seen = '{0, 0, 0};
    send_idle_pct = 0;
    rst <= 1'b1;
    start <= 1'b0;
    operands <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_special_cases();
    drain_results();
    send_idle_pct = 30;
    test_random(650);
    drain_results();
    send_idle_pct = 52;
    test_random(650);
    send_idle_pct = 0;
    test_random(650);
    start <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("Sent %0d beats, checked %0d results.", beats_sent, results_seen);
    $display("Kinds seen: two %0d, one %0d, none %0d.", kind_seen[0], kind_seen[1],
             kind_seen[2]);
    if (fail_count == 0) begin
      $display("PASS quadratic_root_solver");
    end else begin
      $display("FAIL quadratic_root_solver");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/qrs_pkg.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver.sv
test/quadratic_root_solver_tb.sv
